[rtl/fnb_pkg.sv]
// shared constants, types and the square-root table for frequency to note with bend
package fnb_pkg;

  localparam int LOG_FRAC = 16;
  localparam int NOTE_REF = 69;

  localparam logic signed [13:0] NOTE_MAX = 14'sd8191;
  localparam logic signed [13:0] NOTE_MIN = -14'sd8192;

  localparam logic [31:0] ROOT_RESET  = 32'd112640;
  localparam logic [7:0]  STEPS_RESET = 8'd12;

  localparam logic REG_ROOT  = 1'b0;
  localparam logic REG_STEPS = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_ZERO = 2'd1,
    STATUS_SAT  = 2'd2
  } status_t;

  typedef struct packed {
    logic              zero;
    status_t           status;
    logic signed [13:0] note;
    logic              dzero;
    logic              eq;
  } meta_b_t;

  typedef struct packed {
    logic              zero;
    status_t           status;
    logic signed [13:0] note;
    logic              kill;
    logic              neg;
  } meta_c_t;

  typedef logic [16:1][30:0] root_tab_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    logic [63:0] rem;
    res  = '0;
    bitv = 64'h4000_0000_0000_0000;
    rem  = v;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // 2^(2^-k) in q.30, each entry the root of the one before
  function automatic root_tab_t make_roots();
    root_tab_t   t;
    logic [63:0] prev;
    prev = isqrt64(64'h2000_0000_0000_0000);
    t[1] = prev[30:0];
    for (int k = 2; k <= 16; k++) begin
      prev = isqrt64(prev << 30);
      t[k] = prev[30:0];
    end
    return t;
  endfunction

  localparam root_tab_t ROOTS = make_roots();

endpackage

[rtl/fnb_if.sv]
// stream interfaces for frequency beats and note result beats
interface fnb_freq_if;
  logic        valid;
  logic        ready;
  logic [31:0] frequency_in;
  modport source (output valid, output frequency_in, input ready);
  modport sink (input valid, input frequency_in, output ready);
endinterface

interface fnb_note_if;
  logic               valid;
  logic               ready;
  logic signed [13:0] note_number;
  logic signed [7:0]  bend_percent;
  logic [1:0]         status;
  modport source (output valid, output note_number, output bend_percent, output status,
                  input ready);
  modport sink (input valid, input note_number, input bend_percent, input status,
                output ready);
endinterface

[rtl/fnb_log2.sv]
// pipelined log2 by repeated squaring, 17 stages, q5.16 result
module fnb_log2 (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] v,
  output logic [20:0] lg
);

  logic [4:0]  p;
  logic [31:0] y0;
  logic [31:0] y_s  [17];
  logic [15:0] fr_s [17];
  logic [4:0]  p_s  [17];

  always_comb begin
    p = '0;
    for (int i = 1; i < 32; i++) begin
      if (v[i]) p = 5'(i);
    end
    y0 = v << (5'd31 - p);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_s[0]  <= y0;
      fr_s[0] <= '0;
      p_s[0]  <= p;
    end
  end

  for (genvar k = 1; k <= 16; k++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] t;
    assign sq = y_s[k-1] * y_s[k-1];
    assign t  = sq[63:31];
    always_ff @(posedge clk) begin
      if (en) begin
        y_s[k]  <= t[32] ? t[32:1] : t[31:0];
        fr_s[k] <= {fr_s[k-1][14:0], t[32]};
        p_s[k]  <= p_s[k-1];
      end
    end
  end

  assign lg = {p_s[16], fr_s[16]};

endmodule

[rtl/fnb_udiv.sv]
// restoring divider, one quotient bit per stage, 17 stages
module fnb_udiv (
  input  logic        clk,
  input  logic        en,
  input  logic [16:0] dividend,
  input  logic [7:0]  divisor,
  output logic [16:0] quotient
);

  logic [7:0]  rem_r [17];
  logic [16:0] dq_r  [17];

  for (genvar k = 0; k < 17; k++) begin : g_st
    logic [7:0]  rin;
    logic [16:0] din;
    logic [8:0]  part;
    logic [8:0]  diff;
    logic        ge;
    if (k == 0) begin : g_first
      assign rin = '0;
      assign din = dividend;
    end else begin : g_next
      assign rin = rem_r[k-1];
      assign din = dq_r[k-1];
    end
    assign part = {rin, din[16]};
    assign ge   = part >= {1'b0, divisor};
    assign diff = part - {1'b0, divisor};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[7:0] : part[7:0];
        dq_r[k]  <= {din[15:0], ge};
      end
    end
  end

  assign quotient = dq_r[16];

endmodule

[rtl/fnb_exp2.sv]
// pipelined 2^e from the root table, one product per stage, q2.30 result
module fnb_exp2 (
  input  logic        clk,
  input  logic        en,
  input  logic [16:0] e,
  output logic [31:0] pw
);

  logic [30:0] acc_r [16];
  logic [16:0] e_r   [16];

  for (genvar k = 1; k <= 16; k++) begin : g_st
    logic [30:0] ain;
    logic [16:0] ein;
    logic [61:0] prod;
    if (k == 1) begin : g_first
      assign ain = 31'h4000_0000;
      assign ein = e;
    end else begin : g_next
      assign ain = acc_r[k-2];
      assign ein = e_r[k-2];
    end
    assign prod = ain * fnb_pkg::ROOTS[k];
    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[k-1] <= ein[16-k] ? prod[60:30] : ain;
        e_r[k-1]   <= ein;
      end
    end
  end

  assign pw = e_r[15][16] ? {acc_r[15], 1'b0} : {1'b0, acc_r[15]};

endmodule

[rtl/fnb_qdiv.sv]
// bend quotient, 8 bit restoring divide with overflow flag, 8 stages
module fnb_qdiv (
  input  logic        clk,
  input  logic        en,
  input  logic [38:0] mag,
  input  logic [30:0] den,
  output logic [7:0]  quot,
  output logic        ovf
);

  logic [38:0] rem_r [8];
  logic [7:0]  q_r   [8];
  logic [30:0] d_r   [8];
  logic        o_r   [8];

  for (genvar j = 0; j < 8; j++) begin : g_st
    logic [38:0] rin;
    logic [7:0]  qin;
    logic [30:0] dn;
    logic        oin;
    logic [38:0] sh;
    logic        ge;
    if (j == 0) begin : g_first
      assign rin = mag;
      assign qin = '0;
      assign dn  = den;
      assign oin = mag >= {den, 8'b0};
    end else begin : g_next
      assign rin = rem_r[j-1];
      assign qin = q_r[j-1];
      assign dn  = d_r[j-1];
      assign oin = o_r[j-1];
    end
    assign sh = {8'b0, dn} << (7 - j);
    assign ge = rin >= sh;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? rin - sh : rin;
        q_r[j]   <= {qin[6:0], ge};
        d_r[j]   <= dn;
        o_r[j]   <= oin;
      end
    end
  end

  assign quot = q_r[7];
  assign ovf  = o_r[7];

endmodule

[rtl/frequency_to_note_with_bend_top.sv]
// top level: frequency to nearest note number with bend percent
// Usage:
//   freq carries one frequency beat (unsigned q24.8 Hz) per accepted valid/ready cycle.
//   result returns one beat per frequency, in order: note number, bend percent, status.
//   The config port writes root frequency (index 0) or steps per octave (index 1)
//   whenever cfg_we is high; write it only while no beat is in flight.
// Pipeline: an accepted frequency beat passes the input register, 16 squaring stages of
//   the log2, 17 divider stages, 16 product stages of the exp2 and 8 stages of the bend
//   quotient before the output register holds its result beat.
// Throughput: one beat per cycle while result.ready is high.
// Stall: the whole pipeline holds while the output register is full and
//   result.ready is low; freq.ready drops in the same cycle, nothing is lost.
// Reset: rst clears all valid bits and loads root 440 Hz and 12 steps per octave.
module frequency_to_note_with_bend_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [31:0]      cfg_data,
  fnb_freq_if.sink         freq,
  fnb_note_if.source       result
);

  logic [31:0] root;
  logic [7:0]  steps;
  logic [7:0]  dv;
  logic        en;

  always_ff @(posedge clk) begin
    if (rst) begin
      root  <= fnb_pkg::ROOT_RESET;
      steps <= fnb_pkg::STEPS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        fnb_pkg::REG_ROOT:  root  <= cfg_data;
        fnb_pkg::REG_STEPS: steps <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign dv         = (steps == 8'd0) ? 8'd1 : steps;
  assign en         = !result.valid || result.ready;
  assign freq.ready = en;

  // input register
  logic        v0;
  logic [31:0] f0;
  logic        z0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= freq.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f0 <= freq.frequency_in;
      z0 <= (freq.frequency_in == 32'd0) || (root == 32'd0);
    end
  end

  // log2 lanes
  logic [20:0] lgf;
  logic [20:0] lgr;
  logic        va [17];
  logic        za [17];

  fnb_log2 u_log_f (.clk(clk), .en(en), .v(f0),   .lg(lgf));
  fnb_log2 u_log_r (.clk(clk), .en(en), .v(root), .lg(lgr));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 17; i++) va[i] <= 1'b0;
    end else if (en) begin
      va[0] <= v0;
      for (int i = 1; i < 17; i++) va[i] <= va[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      za[0] <= z0;
      for (int i = 1; i < 17; i++) za[i] <= za[i-1];
    end
  end

  // fractional note
  logic signed [21:0] lgd;
  logic signed [8:0]  dv_s;
  logic signed [30:0] prod;
  logic               vx;
  logic               zx;
  logic signed [31:0] x;

  assign lgd  = $signed({1'b0, lgf}) - $signed({1'b0, lgr});
  assign dv_s = $signed({1'b0, dv});
  assign prod = dv_s * lgd;

  always_ff @(posedge clk) begin
    if (rst) begin
      vx <= 1'b0;
    end else if (en) begin
      vx <= va[16];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zx <= za[16];
      x  <= {prod[30], prod} + (32'(fnb_pkg::NOTE_REF) << fnb_pkg::LOG_FRAC);
    end
  end

  // nearest note and saturation
  logic signed [31:0] xr;
  logic signed [15:0] nraw;
  logic               sat_hi;
  logic               sat_lo;
  logic               vn;
  fnb_pkg::meta_b_t   mn;
  logic [15:0]        dn;

  assign xr     = x + 32'sd32768;
  assign nraw   = xr[31:16];
  assign sat_hi = nraw > 16'(fnb_pkg::NOTE_MAX);
  assign sat_lo = nraw < 16'(fnb_pkg::NOTE_MIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      vn <= 1'b0;
    end else if (en) begin
      vn <= vx;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mn.zero   <= zx;
      mn.status <= (sat_hi || sat_lo) ? fnb_pkg::STATUS_SAT : fnb_pkg::STATUS_OK;
      mn.note   <= sat_hi ? fnb_pkg::NOTE_MAX : sat_lo ? fnb_pkg::NOTE_MIN : nraw[13:0];
      mn.dzero  <= (x[15:0] == 16'd0);
      mn.eq     <= !x[15];
      dn        <= x[15:0];
    end
  end

  // exponent quotients and powers
  logic [16:0]      qd;
  logic [16:0]      q1;
  logic [31:0]      ed;
  logic [31:0]      e1;
  logic             vb [33];
  fnb_pkg::meta_b_t mb [33];

  fnb_udiv u_div_d (.clk(clk), .en(en), .dividend({1'b0, dn}), .divisor(dv), .quotient(qd));
  fnb_udiv u_div_1 (.clk(clk), .en(en), .dividend(17'h10000), .divisor(dv), .quotient(q1));
  fnb_exp2 u_exp_d (.clk(clk), .en(en), .e(qd), .pw(ed));
  fnb_exp2 u_exp_1 (.clk(clk), .en(en), .e(q1), .pw(e1));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 33; i++) vb[i] <= 1'b0;
    end else if (en) begin
      vb[0] <= vn;
      for (int i = 1; i < 33; i++) vb[i] <= vb[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mb[0] <= mn;
      for (int i = 1; i < 33; i++) mb[i] <= mb[i-1];
    end
  end

  // bend numerator and denominator
  logic [31:0]        eb;
  logic signed [32:0] num;
  logic signed [32:0] den;
  logic [31:0]        absn;
  logic               den_ok;
  logic               vp;
  fnb_pkg::meta_c_t   mp;
  logic [38:0]        magp;
  logic [30:0]        denp;

  assign eb     = mb[32].eq ? 32'h4000_0000 : e1;
  assign num    = $signed({1'b0, ed}) - $signed({1'b0, eb});
  assign den    = $signed({1'b0, e1}) - 33'sh0_4000_0000;
  assign absn   = num[32] ? 32'(-num) : num[31:0];
  assign den_ok = !den[32] && (den != 33'sd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
    end else if (en) begin
      vp <= vb[32];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mp.zero   <= mb[32].zero;
      mp.status <= mb[32].status;
      mp.note   <= mb[32].note;
      mp.kill   <= mb[32].zero || (mb[32].status != fnb_pkg::STATUS_OK) ||
                   mb[32].dzero || !den_ok;
      mp.neg    <= num[32];
      magp      <= 39'(absn) * 39'd100;
      denp      <= den[30:0];
    end
  end

  // bend quotient
  logic [7:0]       bq_raw;
  logic             bq_ovf;
  logic             vc [8];
  fnb_pkg::meta_c_t mc [8];

  fnb_qdiv u_qdiv (.clk(clk), .en(en), .mag(magp), .den(denp), .quot(bq_raw), .ovf(bq_ovf));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) vc[i] <= 1'b0;
    end else if (en) begin
      vc[0] <= vp;
      for (int i = 1; i < 8; i++) vc[i] <= vc[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mc[0] <= mp;
      for (int i = 1; i < 8; i++) mc[i] <= mc[i-1];
    end
  end

  // output register
  logic [7:0] bq;

  assign bq = (bq_ovf || bq_raw > 8'd100) ? 8'd100 : bq_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= vc[7];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.note_number  <= mc[7].zero ? 14'sd0 : mc[7].note;
      result.bend_percent <= mc[7].kill ? 8'sd0 : mc[7].neg ? $signed(-bq) : $signed(bq);
      result.status       <= mc[7].zero ? fnb_pkg::STATUS_ZERO : mc[7].status;
    end
  end

endmodule
